### rtl/complex_accumulator_alu_top_defines.svh
// Assertion macros for the complex accumulator ALU.
`ifndef COMPLEX_ACCUMULATOR_ALU_TOP_DEFINES_SVH
`define COMPLEX_ACCUMULATOR_ALU_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CAL_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CAL_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cal_pkg.sv
// Shared codes, types and helpers of the complex accumulator ALU.
`default_nettype none
package cal_pkg;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] KIND_CPLX = 2'd0;
  localparam logic [1:0] KIND_REAL = 2'd1;
  localparam logic [1:0] KIND_RAT  = 2'd2;
  localparam logic [1:0] KIND_INT  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] SLOT_RE  = 2'd0;
  localparam logic [1:0] SLOT_IM  = 2'd1;
  localparam logic [1:0] SLOT_DEN = 2'd2;

  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  typedef struct packed {
    logic [1:0] slot;
    logic       sub;
  } cal_tag_t;

  // Clamp to signed 32 bits; bit 32 flags saturation.
  function automatic logic [32:0] clamp66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > MAX32) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < MIN32) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/complex_accumulator_alu_top.sv
// Top level of the complex accumulator ALU: sequencer, accumulator and result register.
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready     op, kind, operand_re/im, numerator, denominator
//  out_     output     out_valid / out_ready   acc_re, acc_im, status
//
// One transaction at a time; in_ready is high only while the sequencer is idle.
// Load/add/subtract are short; multiply uses the shared multiplier, real divide the divider
// twice, complex divide both; a rational operand adds a divide, an integer operand a shift.
// The bit-serial divider (one quotient bit a cycle, 32 bits plus setup) sets the long cases.
// Reset (rst_n low, synchronous) clears the accumulator to 0+0i and empties the output.
// A stalled out_ready holds the result and stops the sequencer at its finish step only.
`default_nettype none
`include "complex_accumulator_alu_top_defines.svh"
module complex_accumulator_alu_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_operand_re,
  input  logic signed [31:0] in_operand_im,
  input  logic signed [31:0] in_numerator,
  input  logic signed [31:0] in_denominator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_acc_re,
  output logic signed [31:0] out_acc_im,
  output logic [1:0]         out_status
);
  import cal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PROMO, S_PWAIT, S_OPER, S_MULT, S_MDRAIN, S_POST, S_DSTART, S_DWAIT, S_FIN
  } state_t;

  state_t state_r;

  // captured transaction
  logic [2:0]         op_r;
  logic [1:0]         kind_r;
  logic signed [31:0] c_r;
  logic signed [31:0] d_r;
  logic signed [31:0] num_r;
  logic signed [31:0] den_r;

  // accumulator and pending new value
  logic signed [31:0] acc_re_r;
  logic signed [31:0] acc_im_r;
  logic signed [31:0] nre_r;
  logic signed [31:0] nim_r;
  logic               zero_r;
  logic               sat_r;

  // product sums: real part (or numerator), imaginary part (or numerator), squared modulus
  logic signed [65:0] s0_r;
  logic signed [65:0] s1_r;
  logic signed [65:0] s2_r;
  logic [2:0]         step_r;
  logic               half_r;
  logic [63:0]        dden_r;
  logic               dneg_r;

  logic               out_valid_r;
  logic signed [31:0] out_re_r;
  logic signed [31:0] out_im_r;
  logic [1:0]         out_status_r;

  logic cplx;
  assign cplx = kind_r == KIND_CPLX;

  logic in_fire;
  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;

  // ---------------- shared multiplier ----------------
  logic signed [31:0] mx, my;
  cal_tag_t           mtag;
  logic [2:0]         mlast;
  logic               mvld;
  logic               mul_pvld;
  logic signed [63:0] mul_p;
  cal_tag_t           mul_ptag;

  // product schedule per operation
  always_comb begin
    mx    = acc_re_r;
    my    = c_r;
    mtag  = '{slot: SLOT_RE, sub: 1'b0};
    mlast = 3'd5;
    if (op_r == OP_MUL && !cplx) begin
      mlast = 3'd1;
      if (step_r != 3'd0) begin
        mx = acc_im_r; mtag.slot = SLOT_IM;
      end
    end else if (op_r == OP_MUL) begin
      mlast = 3'd3;
      unique case (step_r)
        3'd0:    begin mx = acc_re_r; my = c_r; end
        3'd1:    begin mx = acc_im_r; my = d_r; mtag.sub = 1'b1; end
        3'd2:    begin mx = acc_re_r; my = d_r; mtag.slot = SLOT_IM; end
        default: begin mx = acc_im_r; my = c_r; mtag.slot = SLOT_IM; end
      endcase
    end else begin
      unique case (step_r)
        3'd0:    begin mx = c_r; my = c_r; mtag.slot = SLOT_DEN; end
        3'd1:    begin mx = d_r; my = d_r; mtag.slot = SLOT_DEN; end
        3'd2:    begin mx = acc_re_r; my = c_r; end
        3'd3:    begin mx = acc_im_r; my = d_r; end
        3'd4:    begin mx = acc_im_r; my = c_r; mtag.slot = SLOT_IM; end
        default: begin
          mx = acc_re_r; my = d_r; mtag.slot = SLOT_IM; mtag.sub = 1'b1;
        end
      endcase
    end
  end

  assign mvld = state_r == S_MULT;

  cal_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .vld  (mvld),
    .x    (mx),
    .y    (my),
    .tag  (mtag),
    .pvld (mul_pvld),
    .p    (mul_p),
    .ptag (mul_ptag)
  );

  logic signed [65:0] pext, paddend;
  assign pext    = {{2{mul_p[63]}}, mul_p};
  assign paddend = mul_ptag.sub ? -pext : pext;

  // ---------------- shared divider ----------------
  logic               div_start, div_neg, div_busy, div_done, div_sat;
  logic [63:0]        div_mag, div_den;
  logic [31:0]        div_q;
  logic [63:0]        num_ext, den_ext;
  logic [63:0]        num_abs, den_abs;
  logic signed [65:0] dsel;
  logic [65:0]        dsel_abs;

  assign num_ext  = {{32{num_r[31]}}, num_r};
  assign den_ext  = {{32{den_r[31]}}, den_r};
  assign num_abs  = num_r[31] ? (64'd0 - num_ext) : num_ext;
  assign den_abs  = den_r[31] ? (64'd0 - den_ext) : den_ext;
  assign dsel     = half_r ? s1_r : s0_r;
  assign dsel_abs = dsel[65] ? (66'd0 - dsel) : dsel;

  always_comb begin
    if (state_r == S_PROMO) begin
      // rational promoted to Q form; a zero denominator never starts
      div_start = kind_r == KIND_RAT && den_r != 32'sd0;
      div_mag   = num_abs;
      div_neg   = num_r[31] ^ den_r[31];
      div_den   = den_abs;
    end else begin
      div_start = state_r == S_DSTART;
      div_neg   = dsel[65] ^ dneg_r;
      div_mag   = dsel_abs[63:0];
      div_den   = dden_r;
    end
  end

  cal_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .neg  (div_neg),
    .mag  (div_mag),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .q    (div_q),
    .sat  (div_sat)
  );

  // ---------------- add / subtract / scale ----------------
  logic signed [65:0] a66, b66, c66, d66, n66;
  logic [65:0]        c_neg;
  logic [32:0]        add_re, add_im, sub_re, sub_im, mul_re, mul_im, promo_int;
  logic               out_free;

  assign a66    = {{34{acc_re_r[31]}}, acc_re_r};
  assign b66    = {{34{acc_im_r[31]}}, acc_im_r};
  assign c66    = {{34{c_r[31]}}, c_r};
  assign d66    = {{34{d_r[31]}}, d_r};
  assign n66    = {{34{num_r[31]}}, num_r};
  assign c_neg  = 66'd0 - c66;
  // d is zero for non-complex operands, so the imaginary part passes through
  assign add_re = clamp66(a66 + c66);
  assign add_im = clamp66(b66 + d66);
  assign sub_re = clamp66(a66 - c66);
  assign sub_im = clamp66(b66 - d66);
  assign mul_re = clamp66(s0_r >>> FRAC_BITS);
  assign mul_im = clamp66(s1_r >>> FRAC_BITS);
  // integer promoted to Q form by a plain shift
  assign promo_int = clamp66(n66 <<< FRAC_BITS);
  assign out_free = !out_valid_r || out_ready;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;

      // fold in each product as it leaves the multiplier
      if (mul_pvld) begin
        unique case (mul_ptag.slot)
          SLOT_RE:  s0_r <= s0_r + paddend;
          SLOT_IM:  s1_r <= s1_r + paddend;
          default:  s2_r <= s2_r + paddend;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r   <= in_op;
            kind_r <= in_kind;
            c_r    <= in_operand_re;
            d_r    <= (in_kind == KIND_CPLX) ? in_operand_im : 32'sd0;
            num_r  <= in_numerator;
            den_r  <= in_denominator;
            zero_r <= 1'b0;
            sat_r  <= 1'b0;
            half_r <= 1'b0;
            step_r <= '0;
            s0_r   <= '0;
            s1_r   <= '0;
            s2_r   <= '0;
            state_r <= (in_kind == KIND_RAT || in_kind == KIND_INT) ? S_PROMO : S_OPER;
          end
        end
        S_PROMO: begin
          if (kind_r == KIND_INT) begin
            c_r     <= promo_int[31:0];
            sat_r   <= promo_int[32];
            state_r <= S_OPER;
          end else if (div_start) begin
            state_r <= S_PWAIT;
          end else begin
            zero_r  <= 1'b1;
            state_r <= S_FIN;
          end
        end
        S_PWAIT: begin
          if (div_done) begin
            c_r     <= div_q;
            sat_r   <= sat_r | div_sat;
            state_r <= S_OPER;
          end
        end
        S_OPER: begin
          unique case (op_r)
            OP_LOAD: begin
              nre_r <= c_r; nim_r <= d_r; state_r <= S_FIN;
            end
            OP_ADD: begin
              nre_r   <= add_re[31:0];
              nim_r   <= add_im[31:0];
              sat_r   <= sat_r | add_re[32] | add_im[32];
              state_r <= S_FIN;
            end
            OP_SUB: begin
              nre_r   <= sub_re[31:0];
              nim_r   <= sub_im[31:0];
              sat_r   <= sat_r | sub_re[32] | sub_im[32];
              state_r <= S_FIN;
            end
            OP_MUL: state_r <= S_MULT;
            OP_DIV: begin
              if (cplx) begin
                state_r <= S_MULT;
              end else if (c_r == 32'sd0) begin
                zero_r  <= 1'b1;
                state_r <= S_FIN;
              end else begin
                s0_r    <= a66;
                s1_r    <= b66;
                dneg_r  <= c_r[31];
                dden_r  <= c66[65] ? c_neg[63:0] : c66[63:0];
                state_r <= S_DSTART;
              end
            end
            default: begin
              nre_r <= acc_re_r; nim_r <= acc_im_r; state_r <= S_FIN;
            end
          endcase
        end
        S_MULT: begin
          if (step_r == mlast) state_r <= S_MDRAIN;
          else step_r <= step_r + 3'd1;
        end
        S_MDRAIN: state_r <= S_POST;
        S_POST: begin
          if (op_r == OP_MUL) begin
            nre_r   <= mul_re[31:0];
            nim_r   <= mul_im[31:0];
            sat_r   <= sat_r | mul_re[32] | mul_im[32];
            state_r <= S_FIN;
          end else if (s2_r == 66'sd0) begin
            zero_r  <= 1'b1;
            state_r <= S_FIN;
          end else begin
            dden_r  <= s2_r[63:0];
            dneg_r  <= 1'b0;
            state_r <= S_DSTART;
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            sat_r <= sat_r | div_sat;
            if (!half_r) begin
              nre_r   <= div_q;
              half_r  <= 1'b1;
              state_r <= S_DSTART;
            end else begin
              nim_r   <= div_q;
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            if (!zero_r) begin
              acc_re_r <= nre_r;
              acc_im_r <= nim_r;
            end
            out_re_r     <= zero_r ? acc_re_r : nre_r;
            out_im_r     <= zero_r ? acc_im_r : nim_r;
            out_status_r <= zero_r ? ST_ZERO : (sat_r ? ST_SAT : ST_OK);
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_acc_re = out_re_r;
  assign out_acc_im = out_im_r;
  assign out_status = out_status_r;

  logic fin_zero;
  assign fin_zero = state_r == S_FIN && zero_r;

  `CAL_CHECK(a_div_free, div_start, !div_busy, "divider started while busy")
  `CAL_CHECK(a_mul_owner, mul_pvld, state_r == S_MULT || state_r == S_MDRAIN, "stray product")
  `CAL_CHECK_NEXT(a_one_item, in_fire, !in_ready, "second transaction taken during work")
  `CAL_CHECK_NEXT(a_zero_hold, fin_zero, $stable({acc_re_r, acc_im_r}), "zero divisor moved acc")
endmodule
`default_nettype wire

### rtl/cal_mul.sv
// Shared registered 32x32 signed multiplier with a tag carried alongside.
`default_nettype none
module cal_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld,
  input  logic signed [31:0]  x,
  input  logic signed [31:0]  y,
  input  cal_pkg::cal_tag_t   tag,
  output logic                pvld,
  output logic signed [63:0]  p,
  output cal_pkg::cal_tag_t   ptag
);
  import cal_pkg::*;

  logic              pvld_r;
  logic signed [63:0] p_r;
  cal_tag_t          tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= x * y;
    tag_r <= tag;
  end

  assign pvld = pvld_r;
  assign p    = p_r;
  assign ptag = tag_r;
endmodule
`default_nettype wire

### rtl/cal_div.sv
// Bit-serial restoring divider: trunc(mag * 2^FRAC_BITS / den), signed, clamped.
`default_nettype none
module cal_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        neg,
  input  logic [63:0] mag,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] q,
  output logic        sat
);
  typedef enum logic [1:0] {D_IDLE, D_RUN, D_CLAMP} dstate_t;

  dstate_t     state_r;
  logic [4:0]  cnt_r;
  logic [63:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] quo_r;
  logic [63:0] den_r;
  logic        neg_r;
  logic        ovf_r;
  logic        done_r;
  logic [31:0] q_r;
  logic        sat_r;

  logic [95:0] numx;
  logic [64:0] rem2;
  logic        ge;
  logic [64:0] rdiff;

  assign numx  = {32'b0, mag} << FRAC_BITS;
  assign rem2  = {rem_r, lo_r[31]};
  assign ge    = rem2 >= {1'b0, den_r};
  assign rdiff = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            den_r <= den;
            neg_r <= neg;
            rem_r <= numx[95:32];
            lo_r  <= numx[31:0];
            quo_r <= '0;
            cnt_r <= 5'd31;
            // quotient of 2^32 or more: skip the loop
            if (numx[95:32] >= den) begin
              ovf_r   <= 1'b1;
              state_r <= D_CLAMP;
            end else begin
              ovf_r   <= 1'b0;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= ge ? rdiff[63:0] : rem2[63:0];
          lo_r  <= {lo_r[30:0], 1'b0};
          quo_r <= {quo_r[30:0], ge};
          if (cnt_r == 5'd0) state_r <= D_CLAMP;
          else cnt_r <= cnt_r - 5'd1;
        end
        D_CLAMP: begin
          if (ovf_r) begin
            sat_r <= 1'b1;
            q_r   <= neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else if (neg_r) begin
            sat_r <= quo_r > 32'h8000_0000;
            q_r   <= (quo_r > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo_r);
          end else begin
            sat_r <= quo_r[31];
            q_r   <= quo_r[31] ? 32'h7FFF_FFFF : quo_r;
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign busy = state_r != D_IDLE;
  assign done = done_r;
  assign q    = q_r;
  assign sat  = sat_r;
endmodule
`default_nettype wire

### sim/tb_complex_accumulator_alu_top.sv
// Self-checking testbench for the complex accumulator ALU: directed table, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_complex_accumulator_alu_top;
  import cal_pkg::*;

  // Op codes past divide have no package name; the block treats them as no-ops.
  localparam logic [2:0] OP_NOP_LO = 3'd5;
  localparam logic [2:0] OP_NOP_HI = 3'd7;
  localparam int         N_RANDOM  = 1600;
  localparam int         QUIET_TAIL = 150;     // last transactions run without idling
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         DRAIN_CYCLES = 200;   // covers the slowest divide plus margin
  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] QONE = 32'sh0001_0000;

  typedef struct {
    logic [2:0]         op;
    logic [1:0]         kind;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [31:0] num;
    logic signed [31:0] den;
    bit                 fixed;   // expected value typed into the table
    logic signed [31:0] x_re;
    logic signed [31:0] x_im;
    logic [1:0]         x_st;
  } alu_cmd_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         st;
  } acc_view_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_op;
  logic [1:0]         in_kind;
  logic signed [31:0] in_operand_re;
  logic signed [31:0] in_operand_im;
  logic signed [31:0] in_numerator;
  logic signed [31:0] in_denominator;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_acc_re;
  logic signed [31:0] out_acc_im;
  logic [1:0]         out_status;

  complex_accumulator_alu_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_kind        (in_kind),
    .in_operand_re  (in_operand_re),
    .in_operand_im  (in_operand_im),
    .in_numerator   (in_numerator),
    .in_denominator (in_denominator),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_acc_re     (out_acc_re),
    .out_acc_im     (out_acc_im),
    .out_status     (out_status)
  );

  alu_cmd_t           cmd_q[$];
  acc_view_t          pending_acc_q[$];
  logic signed [31:0] model_re;
  logic signed [31:0] model_im;
  int                 err_count;
  int                 cycle_count;
  bit                 quiet;
  bit                 in_fire_n;
  bit                 out_fire_n;
  acc_view_t          out_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both handshakes mid-cycle: inputs and DUT outputs are settled here,
  // so the posedge processes read the decision without racing the DUT.
  always @(negedge clk) begin
    in_fire_n   = in_valid && in_ready && rst_n;
    out_fire_n  = out_valid && out_ready && rst_n;
    out_seen.re = out_acc_re;
    out_seen.im = out_acc_im;
    out_seen.st = out_status;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (t=%0t)", what, got, want, $realtime);
    err_count++;
  endtask

  // Clamp to signed 32 bits and flag saturation.
  function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                 inout logic sat);
    if (v > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return QMAX;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return QMIN;
    end
    return v[31:0];
  endfunction

  // Advance the accumulator model by one transaction and return what the block reports.
  function automatic acc_view_t step_accumulator(input alu_cmd_t t);
    logic signed [127:0] a, b, c, d, n, dn, den2;
    logic signed [31:0]  nre, nim;
    logic                sat, zero, cplx;
    acc_view_t           r;
    a = model_re;
    b = model_im;
    c = 0;
    d = 0;
    n = t.num;
    dn = t.den;
    sat = 1'b0;
    zero = 1'b0;
    cplx = (t.kind == KIND_CPLX);
    nre = model_re;
    nim = model_im;
    case (t.kind)
      KIND_CPLX: begin
        c = t.re;
        d = t.im;
      end
      KIND_REAL: c = t.re;
      KIND_RAT: begin
        if (dn == 0) zero = 1'b1;
        else c = clamp_q((n * 65536) / dn, sat);   // truncates toward zero
      end
      default: c = clamp_q(n * 65536, sat);
    endcase
    if (!zero) begin
      case (t.op)
        OP_LOAD: begin
          nre = c[31:0];
          nim = d[31:0];
        end
        OP_ADD: begin
          nre = clamp_q(a + c, sat);
          if (cplx) nim = clamp_q(b + d, sat);
        end
        OP_SUB: begin
          nre = clamp_q(a - c, sat);
          if (cplx) nim = clamp_q(b - d, sat);
        end
        OP_MUL: begin
          // arithmetic shift rounds toward minus infinity
          nre = clamp_q((a * c - b * d) >>> 16, sat);
          nim = clamp_q((a * d + b * c) >>> 16, sat);
        end
        OP_DIV: begin
          if (cplx) begin
            den2 = c * c + d * d;
            if (den2 == 0) zero = 1'b1;
            else begin
              nre = clamp_q(((a * c + b * d) * 65536) / den2, sat);
              nim = clamp_q(((b * c - a * d) * 65536) / den2, sat);
            end
          end else if (c == 0) begin
            zero = 1'b1;
          end else begin
            nre = clamp_q((a * 65536) / c, sat);
            nim = clamp_q((b * 65536) / c, sat);
          end
        end
        default: ;
      endcase
    end
    if (!zero) begin
      model_re = nre;
      model_im = nim;
    end
    r.re = model_re;
    r.im = model_im;
    r.st = zero ? ST_ZERO : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [1:0] kind,
                         input logic signed [31:0] re, input logic signed [31:0] im,
                         input logic signed [31:0] num, input logic signed [31:0] den,
                         input bit fixed = 1'b0, input logic signed [31:0] x_re = 0,
                         input logic signed [31:0] x_im = 0, input logic [1:0] x_st = ST_OK);
    alu_cmd_t t;
    t.op = op;
    t.kind = kind;
    t.re = re;
    t.im = im;
    t.num = num;
    t.den = den;
    t.fixed = fixed;
    t.x_re = x_re;
    t.x_im = x_im;
    t.x_st = x_st;
    cmd_q.push_back(t);
  endtask

  // Mostly modest Q values so chains of operations stay in range, with extremes mixed in.
  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? QMAX : QMIN;
      3:       return 0;
      4:       return $urandom_range(0, 1) ? QONE : -QONE;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_whole();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 0;
      2:       return $urandom_range(0, 1) ? QMAX : QMIN;
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // Directed table: extremes, every op and kind, zero divisors and saturation.
  task automatic build_table();
    add_row(OP_LOAD, KIND_CPLX, QONE, 2 * QONE, 5, 0, 1, QONE, 2 * QONE, ST_OK);
    add_row(OP_ADD,  KIND_REAL, 32'sh0000_8000, 7, 0, 0);
    add_row(OP_SUB,  KIND_CPLX, -3 * QONE, QONE, 0, 0);
    add_row(OP_MUL,  KIND_CPLX, 2 * QONE, -QONE, 0, 0);
    add_row(OP_DIV,  KIND_CPLX, QONE, 3 * QONE, 0, 0);
    add_row(OP_LOAD, KIND_CPLX, QMAX, QMIN, 0, 0, 1, QMAX, QMIN, ST_OK);
    add_row(OP_ADD,  KIND_REAL, QONE, 0, 0, 0, 1, QMAX, QMIN, ST_SAT);
    add_row(OP_DIV,  KIND_REAL, 0, 9, 0, 0, 1, QMAX, QMIN, ST_ZERO);
    add_row(OP_DIV,  KIND_CPLX, 0, 0, 0, 0, 1, QMAX, QMIN, ST_ZERO);
    add_row(OP_LOAD, KIND_RAT, 0, 0, 1, 0, 1, QMAX, QMIN, ST_ZERO);
    add_row(OP_MUL,  KIND_CPLX, QMIN, QMIN, 0, 0);
    add_row(OP_LOAD, KIND_INT, 0, 0, 32767, 0, 1, 32'sh7FFF_0000, 0, ST_OK);
    add_row(OP_LOAD, KIND_INT, 0, 0, 32768, 0, 1, QMAX, 0, ST_SAT);
    add_row(OP_LOAD, KIND_INT, 0, 0, -32768, 3, 1, QMIN, 0, ST_OK);
    add_row(OP_LOAD, KIND_RAT, 0, 0, QMIN, 1, 1, QMIN, 0, ST_SAT);
    add_row(OP_LOAD, KIND_RAT, 0, 0, 1, 3, 1, 32'sh0000_5555, 0, ST_OK);
    add_row(OP_SUB,  KIND_RAT, 0, 0, -7, 2, 0);
    add_row(OP_SUB,  KIND_INT, 0, 0, 4, 0);
    add_row(OP_ADD,  KIND_CPLX, 0, -QONE, 0, 0);
    add_row(OP_MUL,  KIND_REAL, -QONE - 1, 0, 0, 0);
    add_row(OP_MUL,  KIND_RAT, 0, 0, 3, -4);
    add_row(OP_DIV,  KIND_INT, 0, 0, -3, 0);
    add_row(OP_DIV,  KIND_RAT, 0, 0, QMAX, QMIN);
    add_row(OP_NOP_LO, KIND_CPLX, 1, 1, 0, 0);
    add_row(OP_NOP_HI, KIND_RAT, 0, 0, QMAX, 1);
  endtask

  task automatic build_random();
    alu_cmd_t t;
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 15))
        0, 1, 2: t.op = OP_LOAD;
        3, 4:    t.op = OP_ADD;
        5, 6:    t.op = OP_SUB;
        7, 8, 9: t.op = OP_MUL;
        15:      t.op = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));
        default: t.op = OP_DIV;
      endcase
      t.kind = 2'($urandom_range(KIND_CPLX, KIND_INT));
      t.re = pick_q();
      t.im = pick_q();
      t.num = pick_whole();
      t.den = ($urandom_range(0, 11) == 0) ? 0 : pick_whole();
      if (t.den == 0 && $urandom_range(0, 1)) t.den = 1;
      t.fixed = 1'b0;
      cmd_q.push_back(t);
    end
  endtask

  // Sender: drive each transaction, hold it until accepted, then predict.
  initial begin
    alu_cmd_t  t;
    acc_view_t r;
    int        total;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_kind = KIND_CPLX;
    in_operand_re = 0;
    in_operand_im = 0;
    in_numerator = 0;
    in_denominator = 0;
    err_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    model_re = 0;
    model_im = 0;
    build_table();
    build_random();
    total = cmd_q.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < total; i++) begin
      t = cmd_q.pop_front();
      quiet = (i >= total - QUIET_TAIL);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_op <= t.op;
      in_kind <= t.kind;
      in_operand_re <= t.re;
      in_operand_im <= t.im;
      in_numerator <= t.num;
      in_denominator <= t.den;
      do @(posedge clk); while (!in_fire_n);
      r = step_accumulator(t);
      if (t.fixed) begin
        r.re = t.x_re;
        r.im = t.x_im;
        r.st = t.x_st;
      end
      pending_acc_q.push_back(r);
    end
    in_valid <= 1'b0;
    while (pending_acc_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Receiver stall: random bursts of backpressure, none during the quiet tail.
  initial begin
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Checker: compare each accepted result with the oldest pending expectation.
  always @(posedge clk) begin
    acc_view_t want;
    if (out_fire_n) begin
      if (pending_acc_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_seen.re, 0);
      end else begin
        want = pending_acc_q.pop_front();
        if (out_seen.re !== want.re) report_mismatch("acc_re", out_seen.re, want.re);
        if (out_seen.im !== want.im) report_mismatch("acc_im", out_seen.im, want.im);
        if (out_seen.st !== want.st) begin
          report_mismatch("status", 32'(out_seen.st), 32'(want.st));
        end
      end
    end
  end

endmodule
`default_nettype wire
